// ----- hw/rtl/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants for the inertia calculator
// Word layouts, widths of the wide intermediates and the shape codes.
// ----------------------------------------------------------------------------
package sic_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int KIND_W        = 3;
   localparam int DIM_W         = 32;
   localparam int MOM_W         = 48;
   localparam int NUM_AXES      = 3;
   localparam int SQ_W          = 64;    // product of two dimensions
   localparam int CUBE_W        = 96;    // product of three dimensions
   localparam int POLY_W        = 101;   // largest shape polynomial (32 a^3)
   localparam int PROD_W        = 133;   // mass times polynomial
   localparam int DENB_W        = 35;    // capsule volume weight 4a + 3L
   localparam int MDIV_W        = 42;    // weight times shape constant
   localparam int CUBE_TERMS    = 4;
   localparam int CHUNKS        = 4;     // 32-bit slices of a polynomial

   typedef enum logic [KIND_W-1:0] {
      SHAPE_BOX      = 3'd0,
      SHAPE_SPHERE   = 3'd1,
      SHAPE_CAPSULE  = 3'd2,
      SHAPE_CYLINDER = 3'd3,
      SHAPE_TORUS    = 3'd4,
      SHAPE_CONE     = 3'd5,
      SHAPE_OTHER    = 3'd6
   } shape_type;

   typedef struct packed {
      logic [KIND_W-1:0] shape_kind;
      logic [DIM_W-1:0]  body_mass;
      logic [DIM_W-1:0]  dim_a;
      logic [DIM_W-1:0]  dim_b;
      logic [DIM_W-1:0]  dim_c;
   } req_type;

   typedef struct packed {
      logic [MOM_W-1:0] moment_x;
      logic [MOM_W-1:0] moment_y;
      logic [MOM_W-1:0] moment_z;
      logic [MOM_W-1:0] inv_moment_x;
      logic [MOM_W-1:0] inv_moment_y;
      logic [MOM_W-1:0] inv_moment_z;
      logic             saturated;
   } rsp_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][POLY_W-1:0] poly;
      logic [NUM_AXES-1:0][MDIV_W-1:0] divisor;
      logic [DIM_W-1:0]                mass;
      logic                            other;
   } poly_type;

   typedef struct packed {
      logic                other;
      logic [DIM_W-1:0]    mass;
      logic [NUM_AXES-1:0] ovf;
      logic [NUM_AXES-1:0] dzero;
   } mom_side_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][MOM_W-1:0] moment;
      logic                           sat;
      logic [NUM_AXES-1:0]            ovf;
      logic [NUM_AXES-1:0]            mzero;
   } rcp_side_type;

endpackage

// ----- hw/rtl/sic_poly.sv -----
// ----------------------------------------------------------------------------
// sic_poly: shape polynomial front end
// Five stages: capsule length, squares, cube partials, cubes, polynomials.
// ----------------------------------------------------------------------------
module sic_poly import sic_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output poly_type out_poly
);

   // stage 1: cylinder length of a capsule, clamped at zero
   logic [DIM_W:0]   two_a, b_ext;
   logic [DIM_W-1:0] len_in;
   logic             v1_ff;
   logic [KIND_W-1:0] kind1_ff;
   logic [DIM_W-1:0] mass1_ff, a1_ff, b1_ff, c1_ff, l1_ff;

   assign two_a  = {in_req.dim_a, 1'b0};
   assign b_ext  = {1'b0, in_req.dim_b};
   assign len_in = (b_ext >= two_a) ? DIM_W'(b_ext - two_a) : '0;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff <= in_req.shape_kind;
         mass1_ff <= in_req.body_mass;
         a1_ff    <= in_req.dim_a;
         b1_ff    <= in_req.dim_b;
         c1_ff    <= in_req.dim_c;
         l1_ff    <= len_in;
      end
   end

   // stage 2: squares (a*l and l*l stand in for b*b and c*c on a capsule)
   logic                           cap1, v2_ff;
   logic [DIM_W-1:0]               x1, y1, y2;
   logic [NUM_AXES-1:0][SQ_W-1:0]  sq_in, sq2_ff;
   logic [DENB_W-1:0]              den_in, den2_ff;
   logic [KIND_W-1:0]              kind2_ff;
   logic [DIM_W-1:0]               mass2_ff, a2_ff, l2_ff;

   assign cap1 = (kind1_ff == SHAPE_CAPSULE);
   assign x1   = cap1 ? a1_ff : b1_ff;
   assign y1   = cap1 ? l1_ff : b1_ff;
   assign y2   = cap1 ? l1_ff : c1_ff;
   assign sq_in[0] = SQ_W'(a1_ff) * SQ_W'(a1_ff);
   assign sq_in[1] = SQ_W'(x1) * SQ_W'(y1);
   assign sq_in[2] = SQ_W'(y2) * SQ_W'(y2);
   assign den_in = cap1 ? DENB_W'({a1_ff, 2'b00}) + DENB_W'({l1_ff, 1'b0}) + DENB_W'(l1_ff)
                        : DENB_W'(1);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind2_ff <= kind1_ff;
         mass2_ff <= mass1_ff;
         a2_ff    <= a1_ff;
         l2_ff    <= l1_ff;
         sq2_ff   <= sq_in;
         den2_ff  <= den_in;
      end
   end

   // stage 3: cube partial products and divisors
   logic [CUBE_TERMS-1:0][SQ_W-1:0]  cx;
   logic [CUBE_TERMS-1:0][DIM_W-1:0] cy;
   logic [CUBE_TERMS-1:0][SQ_W-1:0]  lo_in, hi_in, lo3_ff, hi3_ff;
   logic [6:0]                       kc01, kc2;
   logic [NUM_AXES-1:0][MDIV_W-1:0]  div_in, div3_ff, div4_ff;
   logic                             v3_ff;
   logic [KIND_W-1:0]                kind3_ff;
   logic [DIM_W-1:0]                 mass3_ff;
   logic [NUM_AXES-1:0][SQ_W-1:0]    sq3_ff;

   assign cx = {sq2_ff[2], sq2_ff[2], sq2_ff[0], sq2_ff[0]};
   assign cy = {l2_ff, a2_ff, l2_ff, a2_ff};   // a^3, a^2 l, a l^2, l^3

   always_comb begin
      for (int k = 0; k < CUBE_TERMS; k++) begin
         lo_in[k] = SQ_W'(cx[k][DIM_W-1:0]) * SQ_W'(cy[k]);
         hi_in[k] = SQ_W'(cx[k][SQ_W-1:DIM_W]) * SQ_W'(cy[k]);
      end
      case (kind2_ff)
         SHAPE_BOX:      kc01 = 7'd12;
         SHAPE_SPHERE:   kc01 = 7'd5;
         SHAPE_CAPSULE:  kc01 = 7'd20;
         SHAPE_CYLINDER: kc01 = 7'd12;
         SHAPE_TORUS:    kc01 = 7'd8;
         SHAPE_CONE:     kc01 = 7'd80;
         default:        kc01 = 7'd1;
      endcase
      kc2 = (kind2_ff == SHAPE_CAPSULE) ? 7'd10 : kc01;
   end

   assign div_in[0] = MDIV_W'(den2_ff) * MDIV_W'(kc01);
   assign div_in[1] = MDIV_W'(den2_ff) * MDIV_W'(kc01);
   assign div_in[2] = MDIV_W'(den2_ff) * MDIV_W'(kc2);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind3_ff <= kind2_ff;
         mass3_ff <= mass2_ff;
         sq3_ff   <= sq2_ff;
         lo3_ff   <= lo_in;
         hi3_ff   <= hi_in;
         div3_ff  <= div_in;
      end
   end

   // stage 4: assemble cubes
   logic [CUBE_TERMS-1:0][CUBE_W-1:0] cube_in, cube4_ff;
   logic                              v4_ff;
   logic [KIND_W-1:0]                 kind4_ff;
   logic [DIM_W-1:0]                  mass4_ff;
   logic [NUM_AXES-1:0][SQ_W-1:0]     sq4_ff;

   always_comb begin
      for (int k = 0; k < CUBE_TERMS; k++) begin
         cube_in[k] = CUBE_W'(lo3_ff[k]) + {hi3_ff[k], {DIM_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind4_ff <= kind3_ff;
         mass4_ff <= mass3_ff;
         sq4_ff   <= sq3_ff;
         cube4_ff <= cube_in;
         div4_ff  <= div3_ff;
      end
   end

   // stage 5: shape polynomials
   logic [POLY_W-1:0] pa, pb, pc, ta3, ta2l, tal2, tl3;
   logic [NUM_AXES-1:0][POLY_W-1:0] poly_in;
   logic v5_ff;
   poly_type poly_ff;

   assign pa   = POLY_W'(sq4_ff[0]);
   assign pb   = POLY_W'(sq4_ff[1]);
   assign pc   = POLY_W'(sq4_ff[2]);
   assign ta3  = POLY_W'(cube4_ff[0]);
   assign ta2l = POLY_W'(cube4_ff[1]);
   assign tal2 = POLY_W'(cube4_ff[2]);
   assign tl3  = POLY_W'(cube4_ff[3]);

   always_comb begin
      poly_in = '0;
      case (kind4_ff)
         SHAPE_BOX: begin
            poly_in[0] = pb + pc;
            poly_in[1] = pa + pc;
            poly_in[2] = pa + pb;
         end
         SHAPE_SPHERE: begin
            poly_in[0] = pa << 1;
            poly_in[1] = pa << 1;
            poly_in[2] = pa << 1;
         end
         SHAPE_CAPSULE: begin
            poly_in[0] = ta3 * 7'd32 + ta2l * 7'd45 + tal2 * 7'd20 + tl3 * 7'd5;
            poly_in[1] = poly_in[0];
            poly_in[2] = ta3 * 7'd16 + ta2l * 7'd15;
         end
         SHAPE_CYLINDER: begin
            poly_in[0] = pb + pa * 7'd3;
            poly_in[1] = poly_in[0];
            poly_in[2] = pa * 7'd6;
         end
         SHAPE_TORUS: begin
            poly_in[0] = pb * 7'd5 + pa * 7'd4;
            poly_in[1] = poly_in[0];
            poly_in[2] = pb * 7'd6 + pa * 7'd8;
         end
         SHAPE_CONE: begin
            poly_in[0] = pa * 7'd12 + pb * 7'd3;
            poly_in[1] = poly_in[0];
            poly_in[2] = pa * 7'd24;
         end
         default: poly_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         poly_ff.poly    <= poly_in;
         poly_ff.divisor <= div4_ff;
         poly_ff.mass    <= mass4_ff;
         poly_ff.other   <= (kind4_ff >= SHAPE_OTHER);
      end
   end

   assign out_valid = v5_ff;
   assign out_poly  = poly_ff;

endmodule

// ----- hw/rtl/sic_mul.sv -----
// ----------------------------------------------------------------------------
// sic_mul: mass product and divider set-up
// Three stages: 32x32 partials, partial sum, scaling and overflow check.
// ----------------------------------------------------------------------------
module sic_mul import sic_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  poly_type                        in_poly,
   output logic                            out_valid,
   output logic [NUM_AXES-1:0][MDIV_W-1:0] out_rem,
   output logic [NUM_AXES-1:0][MDIV_W-1:0] out_div,
   output logic [NUM_AXES-1:0][MOM_W-1:0]  out_num,
   output mom_side_type                    out_side
);

   localparam int PAD_W = CHUNKS * DIM_W;

   // stage 1: partial products of mass and each polynomial slice
   logic [NUM_AXES-1:0][PAD_W-1:0]           padded;
   logic [NUM_AXES-1:0][CHUNKS-1:0][SQ_W-1:0] pp_in, pp1_ff;
   logic [NUM_AXES-1:0][MDIV_W-1:0]          div1_ff, div2_ff;
   logic [DIM_W-1:0]                         mass1_ff, mass2_ff;
   logic                                     other1_ff, other2_ff, v1_ff, v2_ff, v3_ff;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         padded[i] = PAD_W'(in_poly.poly[i]);
         for (int j = 0; j < CHUNKS; j++) begin
            pp_in[i][j] = SQ_W'(padded[i][j*DIM_W +: DIM_W]) * SQ_W'(in_poly.mass);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp1_ff    <= pp_in;
         div1_ff   <= in_poly.divisor;
         mass1_ff  <= in_poly.mass;
         other1_ff <= in_poly.other;
      end
   end

   // stage 2: sum the partials
   logic [NUM_AXES-1:0][PROD_W-1:0] prod_in, prod2_ff;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod_in[i] = '0;
         for (int j = 0; j < CHUNKS; j++) begin
            prod_in[i] = prod_in[i] + (PROD_W'(pp1_ff[i][j]) << (j * DIM_W));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod2_ff  <= prod_in;
         div2_ff   <= div1_ff;
         mass2_ff  <= mass1_ff;
         other2_ff <= other1_ff;
      end
   end

   // stage 3: drop the fraction, check overflow, load first remainder
   logic [NUM_AXES-1:0][PROD_W-1:0] scaled, upper;
   logic [NUM_AXES-1:0][MDIV_W-1:0] rem_in, rem3_ff, div3_ff;
   logic [NUM_AXES-1:0][MOM_W-1:0]  num_in, num3_ff;
   mom_side_type                    side_in, side3_ff;

   always_comb begin
      side_in.other = other2_ff;
      side_in.mass  = mass2_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         scaled[i]        = prod2_ff[i] >> (2 * FRAC_BITS);
         upper[i]         = scaled[i] >> MOM_W;
         side_in.ovf[i]   = (upper[i] >= PROD_W'(div2_ff[i]));
         side_in.dzero[i] = (div2_ff[i] == '0);
         rem_in[i]        = upper[i][MDIV_W-1:0];
         num_in[i]        = scaled[i][MOM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem3_ff  <= rem_in;
         num3_ff  <= num_in;
         div3_ff  <= div2_ff;
         side3_ff <= side_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_rem   = rem3_ff;
   assign out_num   = num3_ff;
   assign out_div   = div3_ff;
   assign out_side  = side3_ff;

endmodule

// ----- hw/rtl/sic_div.sv -----
// ----------------------------------------------------------------------------
// sic_div: pipelined restoring divider, three lanes
// One quotient bit per stage; numerator bits shift out as quotient bits enter.
// ----------------------------------------------------------------------------
module sic_div import sic_pkg::*; #(
   parameter int DIV_W  = MDIV_W,
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [NUM_AXES-1:0][DIV_W-1:0] in_rem,
   input  logic [NUM_AXES-1:0][DIV_W-1:0] in_den,
   input  logic [NUM_AXES-1:0][MOM_W-1:0] in_num,
   input  logic [SIDE_W-1:0]              in_side,
   output logic                           out_valid,
   output logic [NUM_AXES-1:0][MOM_W-1:0] out_quot,
   output logic [SIDE_W-1:0]              out_side
);

   logic                           vld_ff  [MOM_W];
   logic [NUM_AXES-1:0][DIV_W-1:0] rem_ff  [MOM_W];
   logic [NUM_AXES-1:0][DIV_W-1:0] den_ff  [MOM_W];
   logic [NUM_AXES-1:0][MOM_W-1:0] nq_ff   [MOM_W];
   logic [SIDE_W-1:0]              side_ff [MOM_W];

   for (genvar s = 0; s < MOM_W; s++) begin : g_step
      logic                           vld_src;
      logic [NUM_AXES-1:0][DIV_W-1:0] rem_src, den_src, rem_in;
      logic [NUM_AXES-1:0][MOM_W-1:0] nq_src, nq_in;
      logic [SIDE_W-1:0]              side_src;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = in_rem;
         assign den_src  = in_den;
         assign nq_src   = in_num;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign nq_src   = nq_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
         logic [DIV_W:0] cand;
         logic           fit;
         assign cand      = {rem_src[l], nq_src[l][MOM_W-1]};
         assign fit       = (cand >= {1'b0, den_src[l]});
         assign rem_in[l] = fit ? DIV_W'(cand - {1'b0, den_src[l]}) : cand[DIV_W-1:0];
         assign nq_in[l]  = {nq_src[l][MOM_W-2:0], fit};
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[s] <= 1'b0;
         else if (en) vld_ff[s] <= vld_src;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            nq_ff[s]   <= nq_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[MOM_W-1];
   assign out_quot  = nq_ff[MOM_W-1];
   assign out_side  = side_ff[MOM_W-1];

endmodule

// ----- hw/rtl/shape_inertia_calculator.sv -----
// ----------------------------------------------------------------------------
// shape_inertia_calculator: principal moments of primitive shapes
// Moments (Q32.16, saturating) and their reciprocals (Q16.32) for one body per
// word.
// ----------------------------------------------------------------------------
// One body enters per clock while req_stall is low; five stages build the
// shape polynomial, three form mass times polynomial, 48 run the moment
// division (one quotient bit each), one forms the moments, 48 run the
// reciprocal division and one holds the result word. Throughput is one word
// per clock while not stalled. A stall on the result side freezes the whole
// pipeline and is passed straight back as req_stall, so nothing is lost or
// repeated; the result register is the only storage between the two sides.
// Every value is truncated toward zero; a moment or reciprocal that does not
// fit 48 bits is clamped to all ones and sets saturated. Codes 6 and 7 give
// every moment equal to the raw mass. A zero moment gives a zero reciprocal.
// ----------------------------------------------------------------------------
module shape_inertia_calculator import sic_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int RCP_SHIFT = 3 * FRAC_BITS;
   localparam int RCP_HI    = (RCP_SHIFT >= MOM_W) ? RCP_SHIFT - MOM_W : 0;
   localparam int RCP_LO    = (RCP_SHIFT <  MOM_W) ? RCP_SHIFT : 0;
   // 2^(3F) split into a starting remainder and the low numerator word
   localparam logic [MOM_W-1:0] RCP_REM = (RCP_SHIFT >= MOM_W) ? (MOM_W'(1) << RCP_HI) : '0;
   localparam logic [MOM_W-1:0] RCP_NUM = (RCP_SHIFT <  MOM_W) ? (MOM_W'(1) << RCP_LO) : '0;
   localparam logic             RCP_CAN_OVF = (RCP_SHIFT >= MOM_W);
   localparam logic [MOM_W-1:0] MOM_MAX = '1;

   logic en;
   logic rsp_valid_ff;

   // advance everything unless a finished word is held by the receiver
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // polynomial front end
   logic     poly_valid;
   poly_type poly_word;

   sic_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req_word),
      .out_valid (poly_valid),
      .out_poly  (poly_word)
   );

   // mass product
   logic                            mul_valid;
   logic [NUM_AXES-1:0][MDIV_W-1:0] mul_rem, mul_div;
   logic [NUM_AXES-1:0][MOM_W-1:0]  mul_num;
   mom_side_type                    mul_side;

   sic_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (poly_valid),
      .in_poly   (poly_word),
      .out_valid (mul_valid),
      .out_rem   (mul_rem),
      .out_div   (mul_div),
      .out_num   (mul_num),
      .out_side  (mul_side)
   );

   // moment division
   logic                                 mdiv_valid;
   logic [NUM_AXES-1:0][MOM_W-1:0]       mdiv_quot;
   logic [$bits(mom_side_type)-1:0]      mdiv_side_vec;
   mom_side_type                         mdiv_side;

   sic_div #(.DIV_W(MDIV_W), .SIDE_W($bits(mom_side_type))) u_mom_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_valid),
      .in_rem    (mul_rem),
      .in_den    (mul_div),
      .in_num    (mul_num),
      .in_side   (mul_side),
      .out_valid (mdiv_valid),
      .out_quot  (mdiv_quot),
      .out_side  (mdiv_side_vec)
   );

   assign mdiv_side = mdiv_side_vec;

   // moment stage: pick mass, zero, clamp or quotient; set up reciprocal
   logic [NUM_AXES-1:0][MOM_W-1:0] mom_in, rrem_in, rnum_in;
   logic [NUM_AXES-1:0][MOM_W-1:0] rrem_ff, rnum_ff, rden_ff;
   rcp_side_type                   rside_in, rside_ff;
   logic                           mom_v_ff;

   always_comb begin
      rside_in.sat = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (mdiv_side.other) begin
            mom_in[i] = MOM_W'(mdiv_side.mass);
         end else if (mdiv_side.dzero[i]) begin
            mom_in[i] = '0;
         end else if (mdiv_side.ovf[i]) begin
            mom_in[i] = MOM_MAX;
         end else begin
            mom_in[i] = mdiv_quot[i];
         end
         if (!mdiv_side.other && !mdiv_side.dzero[i] && mdiv_side.ovf[i]) begin
            rside_in.sat = 1'b1;
         end
         rside_in.moment[i] = mom_in[i];
         rside_in.mzero[i]  = (mom_in[i] == '0);
         rside_in.ovf[i]    = RCP_CAN_OVF && (mom_in[i] != '0) && (mom_in[i] <= RCP_REM);
         rrem_in[i]         = RCP_REM;
         rnum_in[i]         = RCP_NUM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mom_v_ff <= 1'b0;
      else if (en) mom_v_ff <= mdiv_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rrem_ff  <= rrem_in;
         rnum_ff  <= rnum_in;
         rden_ff  <= mom_in;
         rside_ff <= rside_in;
      end
   end

   // reciprocal division
   logic                            rdiv_valid;
   logic [NUM_AXES-1:0][MOM_W-1:0]  rdiv_quot;
   logic [$bits(rcp_side_type)-1:0] rdiv_side_vec;
   rcp_side_type                    rdiv_side;

   sic_div #(.DIV_W(MOM_W), .SIDE_W($bits(rcp_side_type))) u_rcp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mom_v_ff),
      .in_rem    (rrem_ff),
      .in_den    (rden_ff),
      .in_num    (rnum_ff),
      .in_side   (rside_ff),
      .out_valid (rdiv_valid),
      .out_quot  (rdiv_quot),
      .out_side  (rdiv_side_vec)
   );

   assign rdiv_side = rdiv_side_vec;

   // result register
   logic [NUM_AXES-1:0][MOM_W-1:0] inv_in;
   rsp_type                        rsp_in, rsp_ff;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (rdiv_side.mzero[i]) begin
            inv_in[i] = '0;
         end else if (rdiv_side.ovf[i]) begin
            inv_in[i] = MOM_MAX;
         end else begin
            inv_in[i] = rdiv_quot[i];
         end
      end
      rsp_in.moment_x     = rdiv_side.moment[0];
      rsp_in.moment_y     = rdiv_side.moment[1];
      rsp_in.moment_z     = rdiv_side.moment[2];
      rsp_in.inv_moment_x = inv_in[0];
      rsp_in.inv_moment_y = inv_in[1];
      rsp_in.inv_moment_z = inv_in[2];
      rsp_in.saturated    = rdiv_side.sat || (rdiv_side.ovf != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= rdiv_valid;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   a_zero_moment_zero_inverse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.moment_x == '0) |-> (rsp_word.inv_moment_x == '0))
      else $error("zero moment with non-zero reciprocal");

   a_equal_moments_equal_inverses: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.moment_x == rsp_word.moment_y)
         |-> (rsp_word.inv_moment_x == rsp_word.inv_moment_y))
      else $error("equal moments with different reciprocals");

   a_zero_inverse_zero_moment: assert property (@(posedge clock) disable iff (reset)
      (RCP_CAN_OVF && rsp_valid && rsp_word.inv_moment_z == '0) |-> (rsp_word.moment_z == '0))
      else $error("zero reciprocal of a non-zero moment");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result word held");

endmodule
